// ----- design/button_debounce_long_press_core_defines.svh -----
// Assertion macros for the button debounce core.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_CORE_DEFINES_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Property checked outside of reset.
`define BDLP_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);

// Property checked at every edge, reset included.
`define BDLP_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) (prop)) else $error(msg);

`else

`define BDLP_ASSERT(lbl, clk_s, rstn_s, prop, msg)
`define BDLP_ASSERT_ALWAYS(lbl, clk_s, prop, msg)

`endif

`endif

// ----- design/bdlp_pkg.sv -----
package bdlp_pkg;

  localparam int unsigned TimeW = 32;

  // Register indexes on the configuration port
  localparam logic [1:0] CFG_IGNORE_TIME    = 2'd0;
  localparam logic [1:0] CFG_LONG_THRESHOLD = 2'd1;
  localparam logic [1:0] CFG_INVERT_INPUT   = 2'd2;

  // Register reset values
  localparam logic [TimeW-1:0] IGNORE_TIME_RST    = 32'd50;
  localparam logic [TimeW-1:0] LONG_THRESHOLD_RST = 32'd1000;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_PRESS_DB   = 3'd1,
    PH_HELD       = 3'd2,
    PH_LONG_HELD  = 3'd3,
    PH_RELEASE_DB = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_PRESS        = 3'd1,
    EV_RELEASE      = 3'd2,
    EV_LONG_PRESS   = 3'd3,
    EV_LONG_RELEASE = 3'd4
  } event_t;

  typedef struct packed {
    logic [TimeW-1:0] ignore_time;
    logic [TimeW-1:0] long_threshold;
    logic             invert_input;
  } cfg_t;

  typedef struct packed {
    logic             action;
    logic             raw_level;
    logic [TimeW-1:0] now_ms;
  } item_t;

  typedef struct packed {
    phase_t           phase;
    logic [TimeW-1:0] last_change_ms;
    logic             held_level;
  } btn_state_t;

endpackage

// ----- design/bdlp_step.sv -----
// One state machine step for one beat: next button state and event.
module bdlp_step import bdlp_pkg::*; (
  input  cfg_t       cfg,
  input  item_t      item,
  input  btn_state_t cur,
  output btn_state_t nxt,
  output event_t     ev
);

  logic [TimeW-1:0] ign_deadline;
  logic [TimeW-1:0] long_deadline;
  logic             ign_expired;
  logic             long_expired;
  logic             q;

  // Deadlines wrap at 32 bits, unsigned compare against now
  assign ign_deadline  = cur.last_change_ms + cfg.ignore_time;
  assign long_deadline = cur.last_change_ms + cfg.long_threshold;
  assign ign_expired   = ign_deadline < item.now_ms;
  assign long_expired  = long_deadline < item.now_ms;
  assign q             = item.raw_level ^ cfg.invert_input;

  always_comb begin
    nxt = cur;
    ev  = EV_NONE;
    if (item.action) begin
      // forced release debounce, level and time untouched
      nxt.phase = PH_RELEASE_DB;
    end else begin
      nxt.held_level = q;
      unique case (cur.phase)
        PH_IDLE: begin
          if (q) begin
            nxt.phase          = PH_PRESS_DB;
            nxt.last_change_ms = item.now_ms;
            ev                 = EV_PRESS;
          end
        end
        PH_PRESS_DB: begin
          if (ign_expired) begin
            nxt.phase          = PH_HELD;
            nxt.last_change_ms = item.now_ms;
          end
        end
        PH_HELD: begin
          if (!q) begin
            nxt.phase          = PH_RELEASE_DB;
            nxt.last_change_ms = item.now_ms;
            ev                 = EV_RELEASE;
          end else if (long_expired) begin
            nxt.phase          = PH_LONG_HELD;
            nxt.last_change_ms = item.now_ms;
            ev                 = EV_LONG_PRESS;
          end
        end
        PH_LONG_HELD: begin
          if (!q) begin
            nxt.phase          = PH_RELEASE_DB;
            nxt.last_change_ms = item.now_ms;
            ev                 = EV_LONG_RELEASE;
          end
        end
        PH_RELEASE_DB: begin
          if (ign_expired) begin
            nxt.phase = PH_IDLE;
          end
        end
        default: begin
          // unreachable codes hold their phase
          nxt.phase = cur.phase;
        end
      endcase
    end
  end

endmodule

// ----- design/button_debounce_long_press_core.sv -----
// Channel  | ports                                   | direction
// ---------+-----------------------------------------+----------
// input    | in_valid, in_stall, in_action,          | in
//          | in_raw_level, in_now_ms                 |
// result   | out_valid, out_stall, out_event_res,    | out
//          | out_machine_state, out_qualified_level  |
// config   | cfg_we, cfg_index, cfg_data             | in
//
// One beat per cycle while the result is not stalled; each input beat passes
// through the input register, then the state update into the result register.
// The single state machine update between those registers sets the rate.
// Synchronous active-low reset returns the registers to their reset values
// and the machine to idle. A stalled result holds both stages; in_stall
// rises only when both stages are full and the result is stalled.
module button_debounce_long_press_core import bdlp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_action,
  input  logic             in_raw_level,
  input  logic [TimeW-1:0] in_now_ms,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       out_event_res,
  output logic [2:0]       out_machine_state,
  output logic             out_qualified_level,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [TimeW-1:0] cfg_data
);

`include "button_debounce_long_press_core_defines.svh"

  cfg_t       cfg_r;
  item_t      s1_item_r;
  logic       s1_valid_r;
  btn_state_t st_r;
  btn_state_t st_nxt;
  event_t     ev_nxt;
  logic       out_valid_r;
  event_t     out_ev_r;
  phase_t     out_phase_r;
  logic       out_level_r;
  logic       adv;
  logic       s1_fire;

  // pipeline moves when the result register is free or drained
  assign adv      = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ignore_time    <= IGNORE_TIME_RST;
      cfg_r.long_threshold <= LONG_THRESHOLD_RST;
      cfg_r.invert_input   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IGNORE_TIME:    cfg_r.ignore_time    <= cfg_data;
        CFG_LONG_THRESHOLD: cfg_r.long_threshold <= cfg_data;
        CFG_INVERT_INPUT:   cfg_r.invert_input   <= cfg_data[0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= '{action: in_action, raw_level: in_raw_level, now_ms: in_now_ms};
    end
  end

  bdlp_step u_step (
    .cfg  (cfg_r),
    .item (s1_item_r),
    .cur  (st_r),
    .nxt  (st_nxt),
    .ev   (ev_nxt)
  );

  // button state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase          <= PH_IDLE;
      st_r.last_change_ms <= '0;
      st_r.held_level     <= 1'b0;
    end else if (s1_fire) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_ev_r    <= ev_nxt;
      out_phase_r <= st_nxt.phase;
      out_level_r <= st_nxt.held_level;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_event_res       = out_ev_r;
  assign out_machine_state   = out_phase_r;
  assign out_qualified_level = out_level_r;

  `BDLP_ASSERT_ALWAYS(a_rst_clears_out, clk, !rst_n |=> !out_valid, "result valid after reset")
  `BDLP_ASSERT(a_stall_needs_full, clk, rst_n, in_stall |-> (s1_valid_r && out_valid_r), "input stalled with room")
  `BDLP_ASSERT(a_press_phase, clk, rst_n, (out_valid && out_event_res == EV_PRESS) |-> out_machine_state == PH_PRESS_DB, "press without press debounce")
  `BDLP_ASSERT(a_long_phase, clk, rst_n, (out_valid && out_event_res == EV_LONG_PRESS) |-> out_machine_state == PH_LONG_HELD, "long press without long held")
  `BDLP_ASSERT(a_release_phase, clk, rst_n, (out_valid && (out_event_res == EV_RELEASE || out_event_res == EV_LONG_RELEASE)) |-> out_machine_state == PH_RELEASE_DB, "release without release debounce")

endmodule
